### hdl/ihbr_pkg.sv
// Shared types, constants and lookup functions for the HID boot report builder.
package ihbr_pkg;

    localparam int KEY_SLOTS_DEF = 6;
    localparam int MAX_SLOTS     = 6;
    localparam int KEYS_W        = 8 * MAX_SLOTS;

    // event kinds
    localparam logic [4:0] KIND_SYNC = 5'd0;
    localparam logic [4:0] KIND_KEY  = 5'd1;
    localparam logic [4:0] KIND_REL  = 5'd2;

    // codes
    localparam logic [9:0] CODE_SYN_REPORT = 10'd0;
    localparam logic [9:0] CODE_BTN_LEFT   = 10'd272;
    localparam logic [9:0] CODE_BTN_RIGHT  = 10'd273;
    localparam logic [9:0] CODE_BTN_MIDDLE = 10'd274;
    localparam logic [9:0] AXIS_X          = 10'd0;
    localparam logic [9:0] AXIS_Y          = 10'd1;
    localparam logic [9:0] AXIS_WHEEL      = 10'd8;

    // key values
    localparam logic signed [31:0] VAL_PRESS  = 32'sd1;
    localparam logic signed [31:0] VAL_REPEAT = 32'sd2;

    localparam logic signed [31:0] ACC_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ACC_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] MOVE_MAX = 32'sd127;
    localparam logic signed [31:0] MOVE_MIN = -32'sd127;

    localparam logic [0:0] REPORT_KBD   = 1'b0;
    localparam logic [0:0] REPORT_MOUSE = 1'b1;

    typedef struct packed {
        logic [4:0]         kind;
        logic [9:0]         event_code;
        logic signed [31:0] event_value;
    } event_t;

    // decoded event, shared by the keyboard and mouse sections
    typedef struct packed {
        logic               key_evt;    // key event, not auto-repeat
        logic               press;
        logic [7:0]         mod_mask;
        logic [7:0]         usage;
        logic [2:0]         btn_mask;
        logic               axis_x;
        logic               axis_y;
        logic               axis_wheel;
        logic               sync;
        logic signed [31:0] delta;
    } dec_t;

    function automatic logic [7:0] mod_mask_of(input logic [9:0] code);
        case (code)
            10'd29:  return 8'h01;
            10'd42:  return 8'h02;
            10'd56:  return 8'h04;
            10'd125: return 8'h08;
            10'd97:  return 8'h10;
            10'd54:  return 8'h20;
            10'd100: return 8'h40;
            10'd126: return 8'h80;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [2:0] btn_mask_of(input logic [9:0] code);
        case (code)
            CODE_BTN_LEFT:   return 3'b001;
            CODE_BTN_RIGHT:  return 3'b010;
            CODE_BTN_MIDDLE: return 3'b100;
            default:         return 3'b000;
        endcase
    endfunction

    // key code to HID usage, zero = unmapped
    function automatic logic [7:0] usage_of(input logic [6:0] code);
        case (code)
            7'd1:   return 8'h29;
            7'd2:   return 8'h1E;  7'd3:   return 8'h1F;  7'd4:   return 8'h20;
            7'd5:   return 8'h21;  7'd6:   return 8'h22;  7'd7:   return 8'h23;
            7'd8:   return 8'h24;  7'd9:   return 8'h25;  7'd10:  return 8'h26;
            7'd11:  return 8'h27;  7'd12:  return 8'h2D;  7'd13:  return 8'h2E;
            7'd14:  return 8'h2A;  7'd15:  return 8'h2B;  7'd16:  return 8'h14;
            7'd17:  return 8'h1A;  7'd18:  return 8'h08;  7'd19:  return 8'h15;
            7'd20:  return 8'h17;  7'd21:  return 8'h1C;  7'd22:  return 8'h18;
            7'd23:  return 8'h0C;  7'd24:  return 8'h12;  7'd25:  return 8'h13;
            7'd26:  return 8'h2F;  7'd27:  return 8'h30;  7'd28:  return 8'h28;
            7'd30:  return 8'h04;  7'd31:  return 8'h16;  7'd32:  return 8'h07;
            7'd33:  return 8'h09;  7'd34:  return 8'h0A;  7'd35:  return 8'h0B;
            7'd36:  return 8'h0D;  7'd37:  return 8'h0E;  7'd38:  return 8'h0F;
            7'd39:  return 8'h33;  7'd40:  return 8'h34;  7'd41:  return 8'h35;
            7'd43:  return 8'h31;  7'd44:  return 8'h1D;  7'd45:  return 8'h1B;
            7'd46:  return 8'h06;  7'd47:  return 8'h19;  7'd48:  return 8'h05;
            7'd49:  return 8'h11;  7'd50:  return 8'h10;  7'd51:  return 8'h36;
            7'd52:  return 8'h37;  7'd53:  return 8'h38;  7'd55:  return 8'h55;
            7'd57:  return 8'h2C;  7'd58:  return 8'h39;  7'd59:  return 8'h3A;
            7'd60:  return 8'h3B;  7'd61:  return 8'h3C;  7'd62:  return 8'h3D;
            7'd63:  return 8'h3E;  7'd64:  return 8'h3F;  7'd65:  return 8'h40;
            7'd66:  return 8'h41;  7'd67:  return 8'h42;  7'd68:  return 8'h43;
            7'd69:  return 8'h53;  7'd70:  return 8'h47;  7'd71:  return 8'h5F;
            7'd72:  return 8'h60;  7'd73:  return 8'h61;  7'd74:  return 8'h56;
            7'd75:  return 8'h5C;  7'd76:  return 8'h5D;  7'd77:  return 8'h5E;
            7'd78:  return 8'h57;  7'd79:  return 8'h59;  7'd80:  return 8'h5A;
            7'd81:  return 8'h5B;  7'd82:  return 8'h62;  7'd83:  return 8'h63;
            7'd86:  return 8'h64;  7'd87:  return 8'h44;  7'd88:  return 8'h45;
            7'd96:  return 8'h58;  7'd98:  return 8'h54;  7'd99:  return 8'h46;
            7'd102: return 8'h4A;  7'd103: return 8'h52;  7'd104: return 8'h4B;
            7'd105: return 8'h50;  7'd106: return 8'h4F;  7'd107: return 8'h4D;
            7'd108: return 8'h51;  7'd109: return 8'h4E;  7'd110: return 8'h49;
            7'd111: return 8'h4C;  7'd119: return 8'h48;  7'd127: return 8'h65;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] d);
        logic signed [32:0] s;
        s = {a[31], a} + {d[31], d};
        if (s[32] != s[31])
            return s[32] ? ACC_MIN : ACC_MAX;
        return s[31:0];
    endfunction

    function automatic logic signed [7:0] clamp_move(input logic signed [31:0] a);
        if (a > MOVE_MAX)
            return MOVE_MAX[7:0];
        if (a < MOVE_MIN)
            return MOVE_MIN[7:0];
        return a[7:0];
    endfunction

endpackage

### hdl/ihbr_kbd.sv
// Keyboard state: modifier byte and pressed-key slots.
module ihbr_kbd
    import ihbr_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  dec_t              dec,
    output logic              hit,
    output logic [7:0]        mods,
    output logic [KEYS_W-1:0] keys
);

    logic [7:0] mods_reg;
    logic [7:0] mods_next;
    logic [7:0] slot_reg  [KEY_SLOTS];
    logic [7:0] slot_next [KEY_SLOTS];
    logic       mod_hit;
    logic       key_hit;

    assign mod_hit = dec.key_evt && (dec.mod_mask != 8'h00);
    assign key_hit = dec.key_evt && (dec.mod_mask == 8'h00) && (dec.usage != 8'h00);
    assign hit     = mod_hit || key_hit;

    always_comb
    begin
        mods_next = mods_reg;
        if (mod_hit)
        begin
            if (dec.press)
                mods_next = mods_reg | dec.mod_mask;
            else
                mods_next = mods_reg & ~dec.mod_mask;
        end
    end

    always_comb
    begin
        logic held;
        logic done;
        held = 1'b0;
        done = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (slot_reg[i] == dec.usage)
                held = 1'b1;
        end
        if (key_hit)
        begin
            for (int i = 0; i < KEY_SLOTS; i++)
            begin
                if (dec.press)
                begin
                    // first empty slot takes the usage unless already held
                    if (!held && !done && slot_reg[i] == 8'h00)
                    begin
                        slot_next[i] = dec.usage;
                        done = 1'b1;
                    end
                end
                else if (!done && slot_reg[i] == dec.usage)
                begin
                    slot_next[i] = 8'h00;
                    done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mods_reg <= '0;
            for (int i = 0; i < KEY_SLOTS; i++)
                slot_reg[i] <= '0;
        end
        else if (fire)
        begin
            mods_reg <= mods_next;
            for (int i = 0; i < KEY_SLOTS; i++)
                slot_reg[i] <= slot_next[i];
        end
    end

    assign mods = mods_next;

    for (genvar g = 0; g < MAX_SLOTS; g++)
    begin : g_keys
        if (g < KEY_SLOTS)
        begin : g_used
            assign keys[8*g +: 8] = slot_next[g];
        end
        else
        begin : g_unused
            assign keys[8*g +: 8] = 8'h00;
        end
    end

endmodule

### hdl/ihbr_mouse.sv
// Mouse state: button bits and saturating motion accumulators.
module ihbr_mouse
    import ihbr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  dec_t              dec,
    output logic              hit,
    output logic [2:0]        buttons,
    output logic signed [7:0] move_x,
    output logic signed [7:0] move_y,
    output logic signed [7:0] move_wheel
);

    logic [2:0]         btn_reg;
    logic [2:0]         btn_next;
    logic signed [31:0] acc_x_reg;
    logic signed [31:0] acc_y_reg;
    logic signed [31:0] acc_w_reg;
    logic               btn_hit;
    logic               sync_hit;

    assign btn_hit  = dec.key_evt && (dec.mod_mask == 8'h00) && (dec.usage == 8'h00)
                      && (dec.btn_mask != 3'b000);
    assign sync_hit = dec.sync
                      && (acc_x_reg != '0 || acc_y_reg != '0 || acc_w_reg != '0);
    assign hit      = btn_hit || sync_hit;

    always_comb
    begin
        btn_next = btn_reg;
        if (btn_hit)
        begin
            if (dec.press)
                btn_next = btn_reg | dec.btn_mask;
            else
                btn_next = btn_reg & ~dec.btn_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            btn_reg   <= '0;
            acc_x_reg <= '0;
            acc_y_reg <= '0;
            acc_w_reg <= '0;
        end
        else if (fire)
        begin
            btn_reg <= btn_next;
            if (hit)
            begin
                // a flush empties all axes
                acc_x_reg <= '0;
                acc_y_reg <= '0;
                acc_w_reg <= '0;
            end
            else if (dec.axis_x)
                acc_x_reg <= sat_add(acc_x_reg, dec.delta);
            else if (dec.axis_y)
                acc_y_reg <= sat_add(acc_y_reg, dec.delta);
            else if (dec.axis_wheel)
                acc_w_reg <= sat_add(acc_w_reg, dec.delta);
        end
    end

    assign buttons    = btn_next;
    assign move_x     = clamp_move(acc_x_reg);
    assign move_y     = clamp_move(acc_y_reg);
    assign move_wheel = clamp_move(acc_w_reg);

endmodule

### hdl/input_events_to_hid_boot_reports_core.sv
// Top level of the input event to HID boot keyboard/mouse report builder.
//
// Input channel s_axis: one input event per item. tuser carries the event kind
// (0 sync, 1 key, 2 relative motion), tdata the code and the signed value.
// Output channel m_axis: at most one report per event. tuser[0] is 0 for a
// keyboard report and 1 for a mouse report; tdata carries the lead byte,
// six key usage bytes and the three clamped motion bytes.
//
// Events that change no report (auto-repeat, motion, unmapped codes, syncs
// with no pending motion) are consumed silently and only update state.
//
// An item is held in the input register, then the decode and state update run
// in one pass into the output register, which drives m_axis_tvalid. Throughput
// is one item per cycle while m_axis does not stall.
//
// A stall on m_axis holds the report in the output register; the input
// register keeps one more item, then s_axis_tready drops until the report
// is taken. Reset clears modifiers, key slots, buttons, accumulators and
// both valid flags.
module input_events_to_hid_boot_reports_core
    import ihbr_pkg::*;
#(
    parameter int KEY_SLOTS = KEY_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // event_code[9:0], event_value[41:10], zero pad
    input  logic [4:0]  s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // lead_byte, pressed_keys, move_x, move_y, move_wheel
    output logic [0:0]  m_axis_tuser    // report_kind
);

    // input register
    logic              in_valid_reg;
    event_t            in_reg;
    logic              fire;

    // decode
    dec_t              dec;
    logic              kbd_hit;
    logic [7:0]        kbd_mods;
    logic [KEYS_W-1:0] kbd_keys;
    logic              mouse_hit;
    logic [2:0]        mouse_btns;
    logic signed [7:0] mouse_x;
    logic signed [7:0] mouse_y;
    logic signed [7:0] mouse_w;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [0:0]        out_kind_reg;
    logic [7:0]        out_lead_reg;
    logic [KEYS_W-1:0] out_keys_reg;
    logic signed [7:0] out_x_reg;
    logic signed [7:0] out_y_reg;
    logic signed [7:0] out_w_reg;

    // event moves to the output stage when that stage is free or draining
    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg.kind        <= s_axis_tuser;
            in_reg.event_code  <= s_axis_tdata[9:0];
            in_reg.event_value <= s_axis_tdata[41:10];
        end
    end

    // event decode; auto-repeat drops the key event entirely
    always_comb
    begin
        dec.key_evt    = (in_reg.kind == KIND_KEY) && (in_reg.event_value != VAL_REPEAT);
        dec.press      = (in_reg.event_value == VAL_PRESS);
        dec.mod_mask   = mod_mask_of(in_reg.event_code);
        dec.usage      = (in_reg.event_code[9:7] == 3'b000)
                         ? usage_of(in_reg.event_code[6:0]) : 8'h00;
        dec.btn_mask   = btn_mask_of(in_reg.event_code);
        dec.axis_x     = (in_reg.kind == KIND_REL) && (in_reg.event_code == AXIS_X);
        dec.axis_y     = (in_reg.kind == KIND_REL) && (in_reg.event_code == AXIS_Y);
        dec.axis_wheel = (in_reg.kind == KIND_REL) && (in_reg.event_code == AXIS_WHEEL);
        dec.sync       = (in_reg.kind == KIND_SYNC) && (in_reg.event_code == CODE_SYN_REPORT);
        dec.delta      = in_reg.event_value;
    end

    ihbr_kbd #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_kbd (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .dec   (dec),
        .hit   (kbd_hit),
        .mods  (kbd_mods),
        .keys  (kbd_keys)
    );

    ihbr_mouse u_mouse (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .dec        (dec),
        .hit        (mouse_hit),
        .buttons    (mouse_btns),
        .move_x     (mouse_x),
        .move_y     (mouse_y),
        .move_wheel (mouse_w)
    );

    always_comb
    begin
        if (fire && (kbd_hit || mouse_hit))
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fire && kbd_hit)
        begin
            out_kind_reg <= REPORT_KBD;
            out_lead_reg <= kbd_mods;
            out_keys_reg <= kbd_keys;
            out_x_reg    <= '0;
            out_y_reg    <= '0;
            out_w_reg    <= '0;
        end
        else if (fire && mouse_hit)
        begin
            out_kind_reg <= REPORT_MOUSE;
            out_lead_reg <= {5'b00000, mouse_btns};
            out_keys_reg <= '0;
            out_x_reg    <= mouse_x;
            out_y_reg    <= mouse_y;
            out_w_reg    <= mouse_w;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {out_w_reg, out_y_reg, out_x_reg, out_keys_reg, out_lead_reg};

endmodule

### test/testbench.sv
// Self-checking testbench for the input event to HID boot report builder.
`timescale 1ns / 100ps

module testbench;
    import ihbr_pkg::*;

    // Linux key codes used by the stimulus and the modifier decode
    localparam logic [9:0] KEY_ESC     = 10'd1;
    localparam logic [9:0] KEY_1       = 10'd2;
    localparam logic [9:0] KC_LCTRL    = 10'd29;
    localparam logic [9:0] KEY_A       = 10'd30;
    localparam logic [9:0] KC_LSHIFT   = 10'd42;
    localparam logic [9:0] KC_RSHIFT   = 10'd54;
    localparam logic [9:0] KC_LALT     = 10'd56;
    localparam logic [9:0] KC_SPACEBAR = 10'd57;
    localparam logic [9:0] KC_RCTRL    = 10'd97;
    localparam logic [9:0] KC_RALT     = 10'd100;
    localparam logic [9:0] KC_LGUI     = 10'd125;
    localparam logic [9:0] KC_RGUI     = 10'd126;
    localparam logic [9:0] CODE_TOP    = 10'd767;

    localparam logic signed [31:0] VAL_RELEASE = 32'sd0;
    localparam logic [4:0]         KIND_TOP    = 5'd31;

    localparam int EVENT_COUNT = 700;
    localparam int WAIT_MAX    = 18;

    typedef struct packed {
        logic              report_kind;
        logic [7:0]        lead_byte;
        logic [47:0]       pressed_keys;
        logic signed [7:0] move_x;
        logic signed [7:0] move_y;
        logic signed [7:0] move_wheel;
    } hid_report_t;

    // Tracks the keyboard/mouse state and queues the reports each event should produce.
    class hid_report_board;
        logic [7:0]  mod_state;
        logic [7:0]  slot [6];
        logic [2:0]  btn_state;
        longint      acc_x;
        longint      acc_y;
        longint      acc_w;
        logic [7:0]  usage_map [128];
        hid_report_t awaiting [$];
        int          n_events;
        int          n_kbd;
        int          n_mouse;
        int          n_bad;

        function new();
            // key code -> HID usage, zero where the key has no usage
            usage_map = '{
                8'h00, 8'h29, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23,
                8'h24, 8'h25, 8'h26, 8'h27, 8'h2D, 8'h2E, 8'h2A, 8'h2B,
                8'h14, 8'h1A, 8'h08, 8'h15, 8'h17, 8'h1C, 8'h18, 8'h0C,
                8'h12, 8'h13, 8'h2F, 8'h30, 8'h28, 8'h00, 8'h04, 8'h16,
                8'h07, 8'h09, 8'h0A, 8'h0B, 8'h0D, 8'h0E, 8'h0F, 8'h33,
                8'h34, 8'h35, 8'h00, 8'h31, 8'h1D, 8'h1B, 8'h06, 8'h19,
                8'h05, 8'h11, 8'h10, 8'h36, 8'h37, 8'h38, 8'h00, 8'h55,
                8'h00, 8'h2C, 8'h39, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
                8'h3F, 8'h40, 8'h41, 8'h42, 8'h43, 8'h53, 8'h47, 8'h5F,
                8'h60, 8'h61, 8'h56, 8'h5C, 8'h5D, 8'h5E, 8'h57, 8'h59,
                8'h5A, 8'h5B, 8'h62, 8'h63, 8'h00, 8'h00, 8'h64, 8'h44,
                8'h45, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h58, 8'h00, 8'h54, 8'h46, 8'h00, 8'h00, 8'h4A, 8'h52,
                8'h4B, 8'h50, 8'h4F, 8'h4D, 8'h51, 8'h4E, 8'h49, 8'h4C,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h48,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h65
            };
            mod_state = '0;
            btn_state = '0;
            foreach (slot[i]) slot[i] = '0;
            acc_x = 0;
            acc_y = 0;
            acc_w = 0;
            n_events = 0;
            n_kbd = 0;
            n_mouse = 0;
            n_bad = 0;
        endfunction

        function logic [7:0] modifier_of(logic [9:0] code);
            case (code)
                KC_LCTRL:  return 8'h01;
                KC_LSHIFT: return 8'h02;
                KC_LALT:   return 8'h04;
                KC_LGUI:   return 8'h08;
                KC_RCTRL:  return 8'h10;
                KC_RSHIFT: return 8'h20;
                KC_RALT:   return 8'h40;
                KC_RGUI:   return 8'h80;
                default:   return 8'h00;
            endcase
        endfunction

        function logic [2:0] button_of(logic [9:0] code);
            case (code)
                CODE_BTN_LEFT:   return 3'b001;
                CODE_BTN_RIGHT:  return 3'b010;
                CODE_BTN_MIDDLE: return 3'b100;
                default:         return 3'b000;
            endcase
        endfunction

        function longint saturate(longint acc, logic signed [31:0] delta);
            longint s;
            s = acc + longint'(delta);
            if (s > longint'(ACC_MAX)) return longint'(ACC_MAX);
            if (s < longint'(ACC_MIN)) return longint'(ACC_MIN);
            return s;
        endfunction

        function logic [7:0] clamp_byte(longint v);
            longint c;
            c = v;
            if (c > longint'(MOVE_MAX)) c = longint'(MOVE_MAX);
            if (c < longint'(MOVE_MIN)) c = longint'(MOVE_MIN);
            return c[7:0];
        endfunction

        function void push_keyboard();
            hid_report_t r;
            r = '0;
            r.report_kind  = REPORT_KBD;
            r.lead_byte    = mod_state;
            r.pressed_keys = {slot[5], slot[4], slot[3], slot[2], slot[1], slot[0]};
            awaiting.push_back(r);
        endfunction

        // a mouse report always drains the motion accumulators
        function void push_mouse();
            hid_report_t r;
            r = '0;
            r.report_kind = REPORT_MOUSE;
            r.lead_byte   = {5'b0, btn_state};
            r.move_x      = clamp_byte(acc_x);
            r.move_y      = clamp_byte(acc_y);
            r.move_wheel  = clamp_byte(acc_w);
            acc_x = 0;
            acc_y = 0;
            acc_w = 0;
            awaiting.push_back(r);
        endfunction

        function void note_event(logic [4:0] kind, logic [9:0] code,
                                 logic signed [31:0] value);
            logic       press;
            logic       done;
            logic [7:0] m;
            logic [7:0] usage;
            logic [2:0] b;
            n_events++;
            if (kind == KIND_KEY) begin
                if (value == VAL_REPEAT)
                    return;
                // anything other than a press is a release
                press = (value == VAL_PRESS);
                m = modifier_of(code);
                usage = (code < 10'd128) ? usage_map[code[6:0]] : 8'h00;
                b = button_of(code);
                if (m != 0) begin
                    mod_state = press ? (mod_state | m) : (mod_state & ~m);
                    push_keyboard();
                end
                else if (usage != 0) begin
                    done = 1'b0;
                    if (press) begin
                        // already held: no change; all slots full: dropped
                        foreach (slot[i])
                            if (slot[i] == usage) done = 1'b1;
                        foreach (slot[i])
                            if (!done && slot[i] == 8'h00) begin
                                slot[i] = usage;
                                done = 1'b1;
                            end
                    end
                    else begin
                        foreach (slot[i])
                            if (!done && slot[i] == usage) begin
                                slot[i] = 8'h00;
                                done = 1'b1;
                            end
                    end
                    push_keyboard();
                end
                else if (b != 0) begin
                    btn_state = press ? (btn_state | b) : (btn_state & ~b);
                    push_mouse();
                end
            end
            else if (kind == KIND_REL) begin
                if (code == AXIS_X)
                    acc_x = saturate(acc_x, value);
                else if (code == AXIS_Y)
                    acc_y = saturate(acc_y, value);
                else if (code == AXIS_WHEEL)
                    acc_w = saturate(acc_w, value);
            end
            else if (kind == KIND_SYNC && code == CODE_SYN_REPORT) begin
                if (acc_x != 0 || acc_y != 0 || acc_w != 0)
                    push_mouse();
            end
        endfunction

        function logic field_ok(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_report(hid_report_t got);
            hid_report_t want;
            logic        ok;
            if (awaiting.size() == 0) begin
                $error("report with none expected: kind %0d, data %0h",
                       got.report_kind, got);
                n_bad++;
                return;
            end
            want = awaiting.pop_front();
            ok = 1'b1;
            ok &= field_ok("report_kind", want.report_kind, got.report_kind);
            ok &= field_ok("lead_byte", want.lead_byte, got.lead_byte);
            ok &= field_ok("pressed_keys", want.pressed_keys, got.pressed_keys);
            ok &= field_ok("move_x", want.move_x, got.move_x);
            ok &= field_ok("move_y", want.move_y, got.move_y);
            ok &= field_ok("move_wheel", want.move_wheel, got.move_wheel);
            if (!ok)
                n_bad++;
            if (want.report_kind == REPORT_MOUSE)
                n_mouse++;
            else
                n_kbd++;
        endfunction

        function int pending();
            return awaiting.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        ev_valid;
    logic        ev_ready;
    logic [47:0] ev_data;
    logic [4:0]  ev_kind;
    logic        rpt_valid;
    logic        rpt_ready;
    logic [79:0] rpt_data;
    logic [0:0]  rpt_kind;

    hid_report_board board;
    int          send_mode;
    int          take_mode;

    input_events_to_hid_boot_reports_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (ev_valid),
        .s_axis_tready (ev_ready),
        .s_axis_tdata  (ev_data),   // event_code[9:0], event_value[41:10], zero pad
        .s_axis_tuser  (ev_kind),   // kind
        .m_axis_tvalid (rpt_valid),
        .m_axis_tready (rpt_ready),
        .m_axis_tdata  (rpt_data),  // lead_byte, pressed_keys, move_x, move_y, move_wheel
        .m_axis_tuser  (rpt_kind)   // report_kind
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mode 0: back to back, 1: uniform gaps, 2: occasional gaps.
    function automatic int draw_wait(int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, WAIT_MAX);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, WAIT_MAX) : 0;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_event(logic [4:0] kind, logic [9:0] code, logic signed [31:0] value);
        int gap;
        if ($urandom_range(0, 31) == 0)
            send_mode = $urandom_range(0, 2);
        gap = draw_wait(send_mode);
        if (gap > 0)
        begin
            ev_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        ev_valid = 1'b1;
        ev_kind  = kind;
        ev_data  = {6'b0, value, code};
        do
            @(posedge clk);
        while (!ev_ready);
        board.note_event(kind, code, value);
        @(negedge clk);
    endtask

    task automatic key(logic [9:0] code, logic signed [31:0] value);
        send_event(KIND_KEY, code, value);
    endtask

    task automatic send_random_event();
        logic [4:0]         kind;
        logic [9:0]         code;
        logic signed [31:0] value;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            kind = KIND_KEY;
            // a narrow pool of codes so that presses and releases meet
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: code = 10'($urandom_range(1, 16));
                5:
                begin
                    case ($urandom_range(0, 7))
                        0:       code = KC_LCTRL;
                        1:       code = KC_LSHIFT;
                        2:       code = KC_LALT;
                        3:       code = KC_LGUI;
                        4:       code = KC_RCTRL;
                        5:       code = KC_RSHIFT;
                        6:       code = KC_RALT;
                        default: code = KC_RGUI;
                    endcase
                end
                6:       code = 10'($urandom_range(CODE_BTN_LEFT, CODE_BTN_MIDDLE));
                7:       code = 10'($urandom_range(0, CODE_TOP));
                default: code = 10'($urandom_range(1, 127));
            endcase
            r = $urandom_range(0, 19);
            if (r < 11)
                value = VAL_PRESS;
            else if (r < 16)
                value = VAL_RELEASE;
            else if (r < 18)
                value = VAL_REPEAT;
            else
                value = $urandom;
        end
        else if (r < 70)
        begin
            kind = KIND_REL;
            case ($urandom_range(0, 9))
                0, 1, 2: code = AXIS_X;
                3, 4, 5: code = AXIS_Y;
                6, 7:    code = AXIS_WHEEL;
                default: code = 10'($urandom_range(0, CODE_TOP));
            endcase
            if ($urandom_range(0, 9) == 0)
                value = $urandom;
            else
                value = $signed($urandom_range(0, 600)) - 300;
        end
        else if (r < 95)
        begin
            kind  = KIND_SYNC;
            code  = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, CODE_TOP))
                                                : CODE_SYN_REPORT;
            value = ($urandom_range(0, 3) == 0) ? $urandom : VAL_RELEASE;
        end
        else
        begin
            kind  = 5'($urandom_range(KIND_REL + 1, KIND_TOP));
            code  = 10'($urandom_range(0, CODE_TOP));
            value = $urandom;
        end
        send_event(kind, code, value);
    endtask

    // Report sink: random back-pressure, each accepted report checked in order.
    initial
    begin
        hid_report_t got;
        int          stall;
        rpt_ready = 1'b0;
        take_mode = 2;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                take_mode = $urandom_range(0, 2);
            stall = draw_wait(take_mode);
            if (stall > 0)
            begin
                rpt_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            rpt_ready = 1'b1;
            do
                @(posedge clk);
            while (!rpt_valid);
            got.report_kind  = rpt_kind[0];
            got.lead_byte    = rpt_data[7:0];
            got.pressed_keys = rpt_data[55:8];
            got.move_x       = rpt_data[63:56];
            got.move_y       = rpt_data[71:64];
            got.move_wheel   = rpt_data[79:72];
            board.check_report(got);
            @(negedge clk);
        end
    end

    // Main sequence: reset, directed events, random events, drain and verdict.
    initial
    begin
        int guard;
        board     = new();
        send_mode = 0;
        rst_n     = 1'b0;
        ev_valid  = 1'b0;
        ev_kind   = '0;
        ev_data   = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // modifiers: set two, clear one later with a plain release
        key(KC_LCTRL, VAL_PRESS);
        key(KC_RGUI, VAL_PRESS);
        // auto-repeat is dropped
        key(KEY_A, VAL_REPEAT);
        // press, then press again while held
        key(KEY_A, VAL_PRESS);
        key(KEY_A, VAL_PRESS);
        // fill the remaining five slots, then one more press is dropped
        for (int c = 0; c < 5; c++)
            key(10'(KEY_1 + c), VAL_PRESS);
        key(KC_SPACEBAR, VAL_PRESS);
        // an odd value counts as a release
        key(KEY_A, 32'sh8000_0000);
        key(KC_LCTRL, VAL_RELEASE);
        // unmapped codes, highest code and code zero
        key(CODE_TOP, VAL_PRESS);
        key(10'd0, VAL_PRESS);
        // accumulator saturation both ways and the -128 clamp
        send_event(KIND_REL, AXIS_X, ACC_MAX);
        send_event(KIND_REL, AXIS_X, 32'sd5);
        send_event(KIND_REL, AXIS_Y, ACC_MIN);
        send_event(KIND_REL, AXIS_Y, -32'sd1);
        send_event(KIND_REL, AXIS_WHEEL, -32'sd128);
        send_event(KIND_REL, CODE_TOP, ACC_MAX);
        // sync with another code does nothing; a real sync flushes, a second does not
        send_event(KIND_SYNC, 10'd5, VAL_RELEASE);
        send_event(KIND_SYNC, CODE_SYN_REPORT, VAL_RELEASE);
        send_event(KIND_SYNC, CODE_SYN_REPORT, VAL_RELEASE);
        // buttons: report at once, flushing pending motion
        key(CODE_BTN_LEFT, VAL_PRESS);
        send_event(KIND_REL, AXIS_X, 32'sd3);
        key(CODE_BTN_MIDDLE, VAL_PRESS);
        key(CODE_BTN_RIGHT, VAL_REPEAT);
        key(CODE_BTN_LEFT, 32'sd7);
        // an unknown kind is ignored
        send_event(KIND_TOP, CODE_TOP, 32'shFFFF_FFFF);
        key(KEY_ESC, VAL_RELEASE);

        send_mode = 2;
        repeat (EVENT_COUNT)
            send_random_event();
        ev_valid = 1'b0;

        guard = 0;
        while (board.pending() != 0 && guard < 10000)
        begin
            @(posedge clk);
            guard++;
        end
        // leave room for any stray report
        repeat (10) @(posedge clk);
        if (board.pending() != 0)
        begin
            $error("%0d expected reports never arrived", board.pending());
            board.n_bad++;
        end

        $display("Events sent: %0d; reports checked: %0d keyboard, %0d mouse.",
                 board.n_events, board.n_kbd, board.n_mouse);
        $display("Covered modifiers, slot fill/drop, repeats, buttons, motion saturation.");
        if (board.n_bad == 0)
            $display("[input_events_to_hid_boot_reports_core] OK");
        else
            $display("[input_events_to_hid_boot_reports_core] ERROR");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout: run did not complete.");
        $display("[input_events_to_hid_boot_reports_core] ERROR");
        $finish;
    end

endmodule
